@@ sv/message_dedup_table_core_defines.svh @@
// assertion macros for the message dedup table checker
// needs a clock and a reset signal in the scope where a macro is used
`ifndef MESSAGE_DEDUP_TABLE_CORE_DEFINES_SVH
`define MESSAGE_DEDUP_TABLE_CORE_DEFINES_SVH

// property checked while reset is low
`define MDT_ASSERT(lbl, prop, txt) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(txt);

// property checked at every edge, reset included
`define MDT_ASSERT_ALWAYS(lbl, prop, txt) \
   lbl: assert property (@(posedge clock) prop) else $error(txt);

`endif

@@ sv/mdt_pkg.sv @@
// shared types and constants for the message dedup table
// used by mdt_front, mdt_back and message_dedup_table_core
package mdt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_DEPTH - 1);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

   localparam logic OP_QUERY    = 1'b0;
   localparam logic OP_REGISTER = 1'b1;

   typedef struct packed {
      logic        operation;
      logic [31:0] source_id;
      logic [31:0] message_id;
      logic [1:0]  new_status;
      logic [31:0] now_time;
   } item_type;

endpackage

@@ sv/mdt_front.sv @@
// front end: takes request words and holds them in a short queue
// depends on mdt_pkg
module mdt_front
   import mdt_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   output logic     busy,
   input  item_type req_item,
   output logic     q_valid,
   output item_type q_item,
   input  logic     q_pop
);

   item_type            slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;
   logic                pop;

   assign busy    = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_item  = slot_ff[rd_ptr_ff];
   assign push    = start && !busy;
   assign pop     = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= req_item;
      end
   end

endmodule

@@ sv/mdt_back.sv @@
// back end: scans the table one entry a cycle, then updates it and returns the result
// depends on mdt_pkg
module mdt_back
   import mdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        q_valid,
   input  item_type    q_item,
   output logic        q_pop,
   output logic        rsp_strobe,
   output logic        rsp_hit,
   output logic        rsp_was_new,
   output logic [1:0]  rsp_found_status,
   output logic [31:0] rsp_found_time
);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_UPDATE = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [IDX_W-1:0]       idx_ff, idx_in;
   logic                   hit_ff, hit_in;
   logic [IDX_W-1:0]       hit_idx_ff, hit_idx_in;
   logic [1:0]             fstat_ff, fstat_in;
   logic [31:0]            ftime_ff, ftime_in;
   logic [CNT_W-1:0]       fill_ff, fill_in;
   logic [IDX_W-1:0]       rptr_ff, rptr_in;
   logic [TABLE_DEPTH-1:0] valid_ff;
   logic                   strobe_ff, strobe_in;
   item_type               item_ff;

   logic                   rsp_hit_ff;
   logic                   rsp_was_new_ff;
   logic [1:0]             rsp_fstat_ff;
   logic [31:0]            rsp_ftime_ff;

   logic [31:0]            src_mem    [TABLE_DEPTH];
   logic [31:0]            msg_mem    [TABLE_DEPTH];
   logic [1:0]             status_mem [TABLE_DEPTH];
   logic [31:0]            time_mem   [TABLE_DEPTH];

   logic                   entry_match;
   logic                   not_full;
   logic [IDX_W-1:0]       new_slot;
   logic                   insert;

   assign entry_match = valid_ff[idx_ff]
                        && (src_mem[idx_ff] == item_ff.source_id)
                        && (msg_mem[idx_ff] == item_ff.message_id);
   assign not_full    = (fill_ff < CNT_W'(TABLE_DEPTH));
   assign new_slot    = not_full ? fill_ff[IDX_W-1:0] : rptr_ff;
   assign insert      = (state_ff == ST_UPDATE) && (item_ff.operation == OP_REGISTER)
                        && !hit_ff;

   always_comb begin
      state_in   = state_ff;
      idx_in     = idx_ff;
      hit_in     = hit_ff;
      hit_idx_in = hit_idx_ff;
      fstat_in   = fstat_ff;
      ftime_in   = ftime_ff;
      fill_in    = fill_ff;
      rptr_in    = rptr_ff;
      strobe_in  = 1'b0;
      q_pop      = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop    = 1'b1;
               state_in = ST_SCAN;
               idx_in   = '0;
               hit_in   = 1'b0;
               fstat_in = '0;
               ftime_in = '0;
            end
         end
         ST_SCAN: begin
            if (entry_match) begin
               hit_in     = 1'b1;
               hit_idx_in = idx_ff;
               fstat_in   = status_mem[idx_ff];
               ftime_in   = time_mem[idx_ff];
               state_in   = ST_UPDATE;
            end else if (idx_ff == LAST_IDX) begin
               state_in = ST_UPDATE;
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         ST_UPDATE: begin
            strobe_in = 1'b1;
            state_in  = ST_IDLE;
            if (insert) begin
               if (not_full) begin
                  fill_in = fill_ff + 1'b1;
               end else begin
                  rptr_in = (rptr_ff == LAST_IDX) ? '0 : rptr_ff + 1'b1;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         idx_ff    <= '0;
         hit_ff    <= 1'b0;
         fill_ff   <= '0;
         rptr_ff   <= '0;
         valid_ff  <= '0;
         strobe_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         idx_ff    <= idx_in;
         hit_ff    <= hit_in;
         fill_ff   <= fill_in;
         rptr_ff   <= rptr_in;
         strobe_ff <= strobe_in;
         if (insert) begin
            valid_ff[new_slot] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      hit_idx_ff <= hit_idx_in;
      fstat_ff   <= fstat_in;
      ftime_ff   <= ftime_in;
      if (q_pop) begin
         item_ff <= q_item;
      end
      if (state_ff == ST_UPDATE) begin
         rsp_hit_ff     <= hit_ff;
         rsp_was_new_ff <= (item_ff.operation == OP_REGISTER) && !hit_ff;
         rsp_fstat_ff   <= fstat_ff;
         rsp_ftime_ff   <= ftime_ff;
      end
   end

   // table writes on a register: refresh a hit in place, otherwise fill or overwrite the oldest slot
   always_ff @(posedge clock) begin
      if (state_ff == ST_UPDATE && item_ff.operation == OP_REGISTER) begin
         if (hit_ff) begin
            status_mem[hit_idx_ff] <= item_ff.new_status;
            time_mem[hit_idx_ff]   <= item_ff.now_time;
         end else begin
            src_mem[new_slot]    <= item_ff.source_id;
            msg_mem[new_slot]    <= item_ff.message_id;
            status_mem[new_slot] <= item_ff.new_status;
            time_mem[new_slot]   <= item_ff.now_time;
         end
      end
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_hit          = rsp_hit_ff;
   assign rsp_was_new      = rsp_was_new_ff;
   assign rsp_found_status = rsp_fstat_ff;
   assign rsp_found_time   = rsp_ftime_ff;

endmodule

@@ sv/message_dedup_table_core.sv @@
// message dedup table: top level joining the request queue and the table engine
// depends on mdt_pkg, mdt_front and mdt_back
//
// A request word (query or register, keyed by source id and message id) is
// taken at a rising edge where start is high and busy is low. busy rises only
// when the two-word request queue is full, so two requests may be handed in
// while the engine is still working on an earlier one.
// The engine pops one word, compares it against the sixteen table entries one
// entry per cycle, stops at the first match, then writes the table in its
// update state and goes back to idle before popping the next word. A miss
// runs the full scan, so throughput is set by the single-entry compare in
// the scan loop.
// Each result shows on the rsp_ ports for one cycle with rsp_strobe high;
// the receiver cannot stall, so results are never held back.
// Synchronous reset empties the queue, marks every table entry invalid and
// clears the fill count and the replacement pointer; no sweep is needed.
module message_dedup_table_core
   import mdt_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic        req_operation,
   input  logic [31:0] req_source_id,
   input  logic [31:0] req_message_id,
   input  logic [1:0]  req_new_status,
   input  logic [31:0] req_now_time,
   output logic        rsp_strobe,
   output logic        rsp_hit,
   output logic        rsp_was_new,
   output logic [1:0]  rsp_found_status,
   output logic [31:0] rsp_found_time
);

   item_type req_item;
   item_type q_item;
   logic     q_valid;
   logic     q_pop;

   always_comb begin
      req_item.operation  = req_operation;
      req_item.source_id  = req_source_id;
      req_item.message_id = req_message_id;
      req_item.new_status = req_new_status;
      req_item.now_time   = req_now_time;
   end

   mdt_front u_front (
      .clock    (clock),
      .reset    (reset),
      .start    (start),
      .busy     (busy),
      .req_item (req_item),
      .q_valid  (q_valid),
      .q_item   (q_item),
      .q_pop    (q_pop)
   );

   mdt_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_item           (q_item),
      .q_pop            (q_pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_hit          (rsp_hit),
      .rsp_was_new      (rsp_was_new),
      .rsp_found_status (rsp_found_status),
      .rsp_found_time   (rsp_found_time)
   );

endmodule

@@ sv/mdt_checker.sv @@
// port-level checks for message_dedup_table_core, attached by bind
// depends on message_dedup_table_core_defines.svh
`include "message_dedup_table_core_defines.svh"

module mdt_checker (
   input logic        clock,
   input logic        reset,
   input logic        busy,
   input logic        rsp_strobe,
   input logic        rsp_hit,
   input logic        rsp_was_new,
   input logic [1:0]  rsp_found_status,
   input logic [31:0] rsp_found_time
);

   logic miss_fields_zero;

   assign miss_fields_zero = (rsp_found_status == 2'd0) && (rsp_found_time == 32'd0);

   // a result takes at least a pop, a scan step and an update, so strobes never touch
   `MDT_ASSERT(a_strobe_gap, rsp_strobe |=> !rsp_strobe, "back-to-back result strobes")

   `MDT_ASSERT(a_new_not_hit, rsp_strobe |-> !(rsp_hit && rsp_was_new), "hit word as new")

   `MDT_ASSERT(a_miss_zero, (rsp_strobe && !rsp_hit) |-> miss_fields_zero, "miss found nonzero")

   `MDT_ASSERT_ALWAYS(a_reset_quiet, $past(reset) |-> (!busy && !rsp_strobe), "active after reset")

endmodule

bind message_dedup_table_core mdt_checker u_mdt_checker (
   .clock            (clock),
   .reset            (reset),
   .busy             (busy),
   .rsp_strobe       (rsp_strobe),
   .rsp_hit          (rsp_hit),
   .rsp_was_new      (rsp_was_new),
   .rsp_found_status (rsp_found_status),
   .rsp_found_time   (rsp_found_time)
);

@@ sim/message_dedup_table_core_tb.sv @@
`timescale 1ns / 1ps
// self-checking testbench for message_dedup_table_core: directed and random query/register words
// predicts each result with a shadow copy of the table; depends on mdt_pkg and the core rtl
module message_dedup_table_core_tb;
   import mdt_pkg::*;

   localparam int STALL_LIMIT     = 2000;
   localparam int KEY_POOL_SIZE   = 24;
   localparam int SOURCE_SET_SIZE = 6;

   typedef struct packed {
      logic        hit;
      logic        was_new;
      logic [1:0]  found_status;
      logic [31:0] found_time;
   } lookup_result_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic        req_operation;
   logic [31:0] req_source_id;
   logic [31:0] req_message_id;
   logic [1:0]  req_new_status;
   logic [31:0] req_now_time;
   logic        rsp_strobe;
   logic        rsp_hit;
   logic        rsp_was_new;
   logic [1:0]  rsp_found_status;
   logic [31:0] rsp_found_time;

   // shadow copy of the dedup table
   logic        tbl_valid   [TABLE_DEPTH];
   logic [31:0] tbl_source  [TABLE_DEPTH];
   logic [31:0] tbl_message [TABLE_DEPTH];
   logic [1:0]  tbl_status  [TABLE_DEPTH];
   logic [31:0] tbl_time    [TABLE_DEPTH];
   int          fill_count;
   int          replace_ptr;

   lookup_result_type pending_results[$];
   logic [31:0]    pool_source  [KEY_POOL_SIZE];
   logic [31:0]    pool_message [KEY_POOL_SIZE];
   int             sender_idle_pct = 0;
   int             fail_count = 0;
   int             quiet_cycles = 0;

   message_dedup_table_core u_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_operation    (req_operation),
      .req_source_id    (req_source_id),
      .req_message_id   (req_message_id),
      .req_new_status   (req_new_status),
      .req_now_time     (req_now_time),
      .rsp_strobe       (rsp_strobe),
      .rsp_hit          (rsp_hit),
      .rsp_was_new      (rsp_was_new),
      .rsp_found_status (rsp_found_status),
      .rsp_found_time   (rsp_found_time)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic lookup_result_type update_shadow_table(item_type word);
      lookup_result_type res;
      int slot;
      res = '0;
      slot = TABLE_DEPTH;
      // lowest matching index wins
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         if (slot == TABLE_DEPTH && tbl_valid[i] && tbl_source[i] == word.source_id &&
             tbl_message[i] == word.message_id)
            slot = i;
      end
      if (slot < TABLE_DEPTH) begin
         res.hit = 1'b1;
         res.found_status = tbl_status[slot];
         res.found_time = tbl_time[slot];
      end
      if (word.operation == OP_REGISTER) begin
         if (slot == TABLE_DEPTH) begin
            if (fill_count < TABLE_DEPTH) begin
               slot = fill_count;
               fill_count++;
            end else begin
               slot = replace_ptr;
               replace_ptr = (replace_ptr + 1) % TABLE_DEPTH;
            end
            tbl_valid[slot] = 1'b1;
            tbl_source[slot] = word.source_id;
            tbl_message[slot] = word.message_id;
            res.was_new = 1'b1;
         end
         tbl_status[slot] = word.new_status;
         tbl_time[slot] = word.now_time;
      end
      return res;
   endfunction

   function automatic item_type make_word(logic op, logic [31:0] source_id,
                                          logic [31:0] message_id, logic [1:0] status,
                                          logic [31:0] stamp);
      item_type w;
      w.operation = op;
      w.source_id = source_id;
      w.message_id = message_id;
      w.new_status = status;
      w.now_time = stamp;
      return w;
   endfunction

   function automatic item_type random_word();
      item_type w;
      int k;
      w.operation = $urandom_range(1) ? OP_REGISTER : OP_QUERY;
      // mostly recurring keys so hits, refills and evictions happen
      if ($urandom_range(99) < 85) begin
         k = $urandom_range(KEY_POOL_SIZE - 1);
         w.source_id = pool_source[k];
         w.message_id = pool_message[k];
      end else begin
         w.source_id = $urandom;
         w.message_id = $urandom;
      end
      w.new_status = 2'($urandom_range(3));
      w.now_time = $urandom;
      return w;
   endfunction

   // drive a word, hold it until taken, then maybe leave a gap
   task automatic send_word(input item_type word);
      req_operation <= word.operation;
      req_source_id <= word.source_id;
      req_message_id <= word.message_id;
      req_new_status <= word.new_status;
      req_now_time <= word.now_time;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      pending_results.push_back(update_shadow_table(word));
      while ($urandom_range(99) < sender_idle_pct) begin
         start <= 1'b0;
         req_operation <= 1'($urandom_range(1));
         req_source_id <= $urandom;
         req_message_id <= $urandom;
         req_new_status <= 2'($urandom_range(3));
         req_now_time <= $urandom;
         @(posedge clock);
      end
   endtask

   task automatic check_field(input string field_name, input logic [31:0] expected,
                              input logic [31:0] actual);
      if (expected !== actual) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field_name,
                  expected, actual);
         fail_count++;
      end
   endtask

   always @(posedge clock) begin : check_result
      lookup_result_type expected;
      if (!reset && rsp_strobe) begin
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual hit %0b was_new %0b",
                     $time, rsp_hit, rsp_was_new);
            fail_count++;
         end else begin
            expected = pending_results.pop_front();
            check_field("hit", 32'(expected.hit), 32'(rsp_hit));
            check_field("was_new", 32'(expected.was_new), 32'(rsp_was_new));
            check_field("found_status", 32'(expected.found_status), 32'(rsp_found_status));
            check_field("found_time", expected.found_time, rsp_found_time);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   task automatic test_empty_table_and_extremes;
      // after reset every entry is invalid, so the zero key must miss at first
      send_word(make_word(OP_QUERY, '0, '0, 2'd3, '1));
      send_word(make_word(OP_REGISTER, '0, '0, 2'd3, '1));
      send_word(make_word(OP_QUERY, '0, '0, 2'd0, '0));
      send_word(make_word(OP_REGISTER, '0, '0, 2'd0, '0));
      send_word(make_word(OP_QUERY, '1, '1, 2'd2, 32'h5555_5555));
      send_word(make_word(OP_REGISTER, '1, '1, 2'd1, 32'h8000_0000));
      send_word(make_word(OP_QUERY, '1, '1, 2'd0, '0));
   endtask

   task automatic test_partial_key_match;
      send_word(make_word(OP_QUERY, '1, '0, 2'd3, '1));
      send_word(make_word(OP_QUERY, '0, '1, 2'd3, '1));
   endtask

   task automatic test_fill_and_wrap;
      for (int i = 0; i < TABLE_DEPTH - 2; i++)
         send_word(make_word(OP_REGISTER, 32'h0000_1000 + i, $urandom,
                             2'($urandom_range(3)), $urandom));
      // table full: next new key evicts slot 0, the zero key
      send_word(make_word(OP_REGISTER, 32'ha5a5_0000, 32'h5a5a_ffff, 2'd2, 32'h1234_5678));
      send_word(make_word(OP_QUERY, '0, '0, 2'd1, '0));
   endtask

   task automatic refresh_key_pool;
      logic [31:0] source_set [SOURCE_SET_SIZE];
      // few sources so keys often share a source id
      for (int i = 0; i < SOURCE_SET_SIZE; i++)
         source_set[i] = $urandom;
      for (int i = 0; i < KEY_POOL_SIZE; i++) begin
         pool_source[i] = source_set[$urandom_range(SOURCE_SET_SIZE - 1)];
         pool_message[i] = $urandom;
      end
   endtask

   task automatic test_random_traffic(input int count, input int idle_pct);
      sender_idle_pct = idle_pct;
      refresh_key_pool();
      repeat (count) send_word(random_word());
   endtask

   initial begin
      reset <= 1'b1;
      start <= 1'b0;
      req_operation <= OP_QUERY;
      req_source_id <= '0;
      req_message_id <= '0;
      req_new_status <= '0;
      req_now_time <= '0;
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         tbl_valid[i] = 1'b0;
         tbl_source[i] = '0;
         tbl_message[i] = '0;
         tbl_status[i] = '0;
         tbl_time[i] = '0;
      end
      fill_count = 0;
      replace_ptr = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      sender_idle_pct = 20;
      test_empty_table_and_extremes();
      test_partial_key_match();
      test_fill_and_wrap();
      test_random_traffic(500, 0);
      test_random_traffic(500, 54);
      test_random_traffic(450, 12);

      start <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (25) @(posedge clock);
      if (fail_count == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+sv
sv/mdt_pkg.sv
sv/mdt_front.sv
sv/mdt_back.sv
sv/message_dedup_table_core.sv
sv/mdt_checker.sv
sim/message_dedup_table_core_tb.sv
